>>> rtl/tre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tre_pkg;

    localparam int MAX_GATES  = 64;
    localparam int TERM_TRITS = 9;
    localparam int TERM_W     = 2 * TERM_TRITS;
    localparam int IDX_W      = $clog2(MAX_GATES);
    localparam int CNT_W      = $clog2(MAX_GATES + 1);
    localparam int TGT_W      = 4;
    localparam int OP_W       = 3;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_EVAL = 1'b1
    } t_func;

    typedef enum logic [OP_W-1:0] {
        OP_MINUS1 = 3'd0,
        OP_MINUS2 = 3'd1,
        OP_SWAP01 = 3'd2,
        OP_SWAP02 = 3'd3,
        OP_SWAP12 = 3'd4
    } t_op;

    typedef struct packed {
        logic [TERM_W-1:0] control;
        logic [TGT_W-1:0]  target;
        logic [OP_W-1:0]   op;
    } t_gate;

    // Trit code three and unused op codes pass the trit unchanged.
    function automatic logic [1:0] perm_trit(input logic [OP_W-1:0] op,
                                             input logic [1:0] trit);
        logic [1:0] res;
        res = trit;
        if (trit != 2'd3) begin
            case (op)
                OP_MINUS1: res = (trit == 2'd0) ? 2'd2 : ((trit == 2'd1) ? 2'd0 : 2'd1);
                OP_MINUS2: res = (trit == 2'd0) ? 2'd1 : ((trit == 2'd1) ? 2'd2 : 2'd0);
                OP_SWAP01: res = (trit == 2'd0) ? 2'd1 : ((trit == 2'd1) ? 2'd0 : 2'd2);
                OP_SWAP02: res = (trit == 2'd0) ? 2'd2 : ((trit == 2'd1) ? 2'd1 : 2'd0);
                OP_SWAP12: res = (trit == 2'd0) ? 2'd0 : ((trit == 2'd1) ? 2'd2 : 2'd1);
                default:   res = trit;
            endcase
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tre_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tre_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_adv,
    input  wire logic                      i_wr,
    input  wire tre_pkg::t_gate            i_gate,
    input  wire logic                      i_active,
    input  wire logic                      i_valid,
    input  wire logic [tre_pkg::TERM_W-1:0] i_term,
    output logic                           o_valid,
    output logic [tre_pkg::TERM_W-1:0]     o_term
);
    import tre_pkg::*;

    t_gate             r_gate;
    logic              r_valid;
    logic [TERM_W-1:0] r_term;
    logic [TERM_W-1:0] n_term;

    logic [TERM_W-1:0] w_mask;
    logic [1:0]        w_trit;
    logic [1:0]        w_new;
    logic              w_hit;
    logic              w_fire;
    logic [TERM_W-1:0] w_placed;

    always_comb begin
        w_mask = '0;
        w_trit = 2'd0;
        for (int k = 0; k < TERM_TRITS; k++) begin
            if (r_gate.target == TGT_W'(k)) begin
                w_mask[2*k +: 2] = 2'b11;
                w_trit           = i_term[2*k +: 2];
            end
        end
        w_hit  = |w_mask;
        w_new  = perm_trit(r_gate.op, w_trit);
        w_fire = i_active && w_hit && ((i_term & ~w_mask) == r_gate.control);
        w_placed = i_term & ~w_mask;
        for (int k = 0; k < TERM_TRITS; k++) begin
            if (r_gate.target == TGT_W'(k)) begin
                w_placed[2*k +: 2] = w_new;
            end
        end
        n_term = w_fire ? w_placed : i_term;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_gate <= i_gate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_term <= n_term;
        end
    end

    assign o_valid = r_valid;
    assign o_term  = r_term;

endmodule

`default_nettype wire

>>> rtl/ternary_reversible_cascade_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Ternary reversible cascade evaluator. Each of the MAX_GATES cells of the
// chain holds one gate and one pipeline stage of the term. Cell 0 registers
// an evaluate transaction at the accepting edge, each following cell takes
// it from the one before, and the output register takes it from the last
// cell. Evaluate transactions are taken one per cycle unless the output
// transaction is stalled. A load transaction writes straight into the cell
// it names and is held off until no evaluate is left in the chain. Cell k
// applies its gate only when k is below gate_count; counts above MAX_GATES
// apply all cells. Gates read before they were ever loaded give undefined
// results; there is no clearing pass. The whole chain holds when the output
// transaction is stalled.
module ternary_reversible_cascade_eval (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [tre_pkg::CNT_W-1:0]   i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_func,
    input  wire logic [tre_pkg::IDX_W-1:0]   i_gate_index,
    input  wire logic [tre_pkg::TERM_W-1:0]  i_gate_control,
    input  wire logic [tre_pkg::TGT_W-1:0]   i_gate_target,
    input  wire logic [tre_pkg::OP_W-1:0]    i_gate_op,
    input  wire logic [tre_pkg::TERM_W-1:0]  i_term,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [tre_pkg::TERM_W-1:0]       o_result_term
);
    import tre_pkg::*;

    logic [CNT_W-1:0]  r_gate_count;
    logic              r_out_valid;
    logic [TERM_W-1:0] r_out_term;

    logic              w_adv;
    logic              w_busy;
    logic              w_accept;
    logic              w_load;
    t_gate             w_gate;

    logic [MAX_GATES:0] w_valid;
    logic [TERM_W-1:0]  w_term [MAX_GATES+1];

    assign w_adv    = !r_out_valid || !i_stall;
    assign w_busy   = |w_valid[MAX_GATES:1];
    assign o_stall  = !w_adv || ((i_func == FUNC_LOAD) && w_busy);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = w_accept && (i_func == FUNC_LOAD);

    assign w_gate.control = i_gate_control;
    assign w_gate.target  = i_gate_target;
    assign w_gate.op      = i_gate_op;

    assign w_valid[0] = w_accept && (i_func == FUNC_EVAL);
    assign w_term[0]  = i_term;

    for (genvar k = 0; k < MAX_GATES; k++) begin : g_cell
        tre_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (w_adv),
            .i_wr     (w_load && (i_gate_index == IDX_W'(k))),
            .i_gate   (w_gate),
            .i_active (CNT_W'(k) < r_gate_count),
            .i_valid  (w_valid[k]),
            .i_term   (w_term[k]),
            .o_valid  (w_valid[k+1]),
            .o_term   (w_term[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_count <= '0;
        end else if (i_cfg_we) begin
            r_gate_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[MAX_GATES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_term <= w_term[MAX_GATES];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_term = r_out_term;

`ifndef SYNTHESIS
    a_load_on_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !w_busy)
        else $error("load transaction taken with evaluates in the chain");

    a_chain_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[MAX_GATES] && !w_adv) |=> w_valid[MAX_GATES])
        else $error("last cell dropped its term during a stall");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_valid[MAX_GATES]))
        else $error("result appeared without a term leaving the chain");
`endif

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import tre_pkg::*;

    localparam int DRAIN_CYCLES = 80;     // 64 cells plus output register, with margin
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;

    typedef enum {CTL_MATCH, CTL_TARGET_SET, CTL_RANDOM} t_ctl_kind;

    typedef struct {
        t_func              func;
        logic [IDX_W-1:0]   index;
        logic [TERM_W-1:0]  control;
        logic [TGT_W-1:0]   target;
        logic [OP_W-1:0]    op;
        logic [TERM_W-1:0]  term;
    } t_request;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]   i_cfg_data     = '0;
    logic               i_valid        = 1'b0;
    logic               o_stall;
    logic               i_func         = 1'b0;
    logic [IDX_W-1:0]   i_gate_index   = '0;
    logic [TERM_W-1:0]  i_gate_control = '0;
    logic [TGT_W-1:0]   i_gate_target  = '0;
    logic [OP_W-1:0]    i_gate_op      = '0;
    logic [TERM_W-1:0]  i_term         = '0;
    logic               o_valid;
    logic               i_stall        = 1'b0;
    logic [TERM_W-1:0]  o_result_term;

    // cascade predictor
    t_gate              cascade_gates [MAX_GATES];
    logic [CNT_W-1:0]   active_count = '0;
    logic [TERM_W-1:0]  expected_terms [$];

    // stimulus planning
    t_request           pending_items [$];
    t_request           offered;
    logic [TERM_W-1:0]  chain_cur;
    logic [TERM_W-1:0]  chain_bases [$];
    logic [TERM_W-1:0]  want_term;

    int  items_pushed   = 0;
    int  items_accepted = 0;
    int  loads_seen     = 0;
    int  evals_seen     = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  count_writes   = 0;
    int  hold_left      = 0;
    int  idle_cycles    = 0;
    bit  calm           = 1'b0;
    bit  hold_ask       = 1'b0;
    bit  hold_done      = 1'b0;

    ternary_reversible_cascade_eval dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_gate_index   (i_gate_index),
        .i_gate_control (i_gate_control),
        .i_gate_target  (i_gate_target),
        .i_gate_op      (i_gate_op),
        .i_term         (i_term),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_term  (o_result_term)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [1:0] permute_trit(logic [OP_W-1:0] op, logic [1:0] v);
        logic [1:0] r;
        r = v;
        case (op)
            OP_MINUS1: r = (v == 2'd0) ? 2'd2 : v - 2'd1;
            OP_MINUS2: r = (v == 2'd2) ? 2'd0 : v + 2'd1;
            OP_SWAP01: r = (v == 2'd2) ? v : v ^ 2'd1;
            OP_SWAP02: r = 2'd2 - v;
            OP_SWAP12: r = (v == 2'd0) ? v : 2'd3 - v;
            default:   r = v;
        endcase
        return r;
    endfunction

    function automatic logic [TERM_W-1:0] fire_gate(t_gate g, logic [TERM_W-1:0] t);
        logic [TERM_W-1:0] rest;
        logic [1:0]        v;
        int                sh;
        if (g.target >= TERM_TRITS)
            return t;
        sh = 2 * int'(g.target);
        rest = t;
        rest[sh +: 2] = 2'd0;
        v = t[sh +: 2];
        if (g.control != rest || v == 2'd3)
            return t;
        rest[sh +: 2] = permute_trit(g.op, v);
        return rest;
    endfunction

    function automatic logic [TERM_W-1:0] run_cascade(logic [TERM_W-1:0] t);
        int n;
        n = (active_count > MAX_GATES) ? MAX_GATES : int'(active_count);
        for (int i = 0; i < n; i++)
            t = fire_gate(cascade_gates[i], t);
        return t;
    endfunction

    function automatic void predict_request(t_request r);
        if (r.func == FUNC_LOAD) begin
            cascade_gates[r.index].control = r.control;
            cascade_gates[r.index].target  = r.target;
            cascade_gates[r.index].op      = r.op;
            loads_seen++;
        end else begin
            expected_terms.push_back(run_cascade(r.term));
            evals_seen++;
        end
    endfunction

    function automatic logic [TERM_W-1:0] clean_term();
        logic [TERM_W-1:0] t;
        for (int i = 0; i < TERM_TRITS; i++)
            t[2*i +: 2] = 2'($urandom_range(0, 2));
        return t;
    endfunction

    function automatic logic [TGT_W-1:0] rand_target();
        if ($urandom_range(0, 9) == 0)
            return TGT_W'($urandom_range(TERM_TRITS, (1 << TGT_W) - 1));
        return TGT_W'($urandom_range(0, TERM_TRITS - 1));
    endfunction

    function automatic logic [OP_W-1:0] rand_op();
        if ($urandom_range(0, 9) == 0)
            return OP_W'($urandom_range(int'(OP_SWAP12) + 1, (1 << OP_W) - 1));
        return OP_W'($urandom_range(int'(OP_MINUS1), int'(OP_SWAP12)));
    endfunction

    function automatic t_ctl_kind rand_kind();
        int k;
        k = $urandom_range(0, 99);
        if (k < 75)
            return CTL_MATCH;
        if (k < 85)
            return CTL_TARGET_SET;
        return CTL_RANDOM;
    endfunction

    // Mostly terms that walk a planned chain, some with one trit bent or set to
    // code three, the rest plain noise.
    function automatic logic [TERM_W-1:0] pick_term();
        logic [TERM_W-1:0] t;
        int                k;
        int                p;
        k = $urandom_range(0, 99);
        t = chain_bases[$urandom_range(0, chain_bases.size() - 1)];
        p = 2 * $urandom_range(0, TERM_TRITS - 1);
        if (k < 20)
            t = TERM_W'($urandom);
        else if (k < 35)
            t[p +: 2] = 2'($urandom_range(0, 2));
        else if (k < 45)
            t[p +: 2] = 2'd3;
        return t;
    endfunction

    task automatic push_load(int idx, logic [TGT_W-1:0] tgt, logic [OP_W-1:0] op,
                             logic [TERM_W-1:0] ctl);
        t_request r;
        r.func    = FUNC_LOAD;
        r.index   = IDX_W'(idx);
        r.control = ctl;
        r.target  = tgt;
        r.op      = op;
        r.term    = TERM_W'($urandom);
        pending_items.push_back(r);
        items_pushed++;
    endtask

    task automatic push_eval(logic [TERM_W-1:0] t);
        t_request r;
        r.func    = FUNC_EVAL;
        r.index   = IDX_W'($urandom);
        r.control = TERM_W'($urandom);
        r.target  = TGT_W'($urandom);
        r.op      = OP_W'($urandom);
        r.term    = t;
        pending_items.push_back(r);
        items_pushed++;
    endtask

    task automatic start_segment();
        chain_cur = clean_term();
        chain_bases.push_back(chain_cur);
    endtask

    // Build the gate so that the planned term fires it (or not), then advance
    // the planned term through it.
    task automatic plan_gate(int idx, logic [TGT_W-1:0] tgt, logic [OP_W-1:0] op,
                             t_ctl_kind kind);
        t_gate g;
        int    sh;
        g.target  = tgt;
        g.op      = op;
        g.control = TERM_W'($urandom);
        if (tgt < TERM_TRITS) begin
            sh = 2 * int'(tgt);
            if (kind == CTL_MATCH) begin
                g.control = chain_cur;
                g.control[sh +: 2] = 2'd0;
            end else if (kind == CTL_TARGET_SET) begin
                g.control = chain_cur;
                g.control[sh +: 2] = 2'($urandom_range(1, 3));
            end
        end else if (kind != CTL_RANDOM) begin
            g.control = chain_cur;
        end
        chain_cur = fire_gate(g, chain_cur);
        push_load(idx, g.target, g.op, g.control);
    endtask

    task automatic drain();
        do
            @(negedge i_clk);
        while (items_accepted != items_pushed || expected_terms.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_count(int v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CNT_W'(v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        active_count = CNT_W'(v);
        count_writes++;
    endtask

    // A negative count selects the chain length.
    task automatic random_phase(int len, int n_evals, int count, bit pressure);
        chain_bases.delete();
        for (int i = 0; i < len; i++) begin
            if (i % 16 == 0 || $urandom_range(0, 15) == 0)
                start_segment();
            plan_gate(i, rand_target(), rand_op(), rand_kind());
        end
        drain();
        set_count(count < 0 ? len : count);
        if (pressure) begin
            calm     = 1'b1;
            hold_ask = 1'b1;
        end
        for (int i = 0; i < n_evals; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_load($urandom_range(0, MAX_GATES - 1), TGT_W'($urandom),
                          OP_W'($urandom), TERM_W'($urandom));
            else
                push_eval(pick_term());
        end
        drain();
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // count is zero out of reset: terms pass straight through
        push_load(MAX_GATES - 1, '1, '1, '1);
        push_eval('0);
        push_eval('1);
        push_eval(clean_term());
        drain();

        // one gate per op code, gates that can never fire, and a last gate on the top trit
        chain_bases.delete();
        start_segment();
        for (int i = 0; i < (1 << OP_W); i++)
            plan_gate(i, TGT_W'(i == 0 ? 0 : $urandom_range(0, TERM_TRITS - 1)),
                      OP_W'(i), CTL_MATCH);
        plan_gate(8, '1, OP_SWAP01, CTL_MATCH);
        plan_gate(9, TGT_W'(TERM_TRITS), OP_MINUS1, CTL_MATCH);
        plan_gate(10, TGT_W'($urandom_range(0, TERM_TRITS - 1)), OP_SWAP12, CTL_TARGET_SET);
        plan_gate(11, TGT_W'(TERM_TRITS - 1), OP_MINUS2, CTL_MATCH);
        drain();
        set_count(12);
        push_eval(chain_bases[0]);
        push_eval(chain_bases[0] | TERM_W'(3));   // first gate matches on a code-three trit
        push_eval('0);
        push_eval('1);
        repeat (4) push_eval(pick_term());
        drain();

        // full cascade, no idling, receiver held off to back up the chain
        random_phase(MAX_GATES, 200, MAX_GATES, 1'b1);

        random_phase($urandom_range(1, MAX_GATES), 100, -1, 1'b0);
        random_phase($urandom_range(1, MAX_GATES), 100, (1 << CNT_W) - 1, 1'b0);
        random_phase($urandom_range(1, MAX_GATES), 100, 1, 1'b0);
        random_phase($urandom_range(1, MAX_GATES), 100, MAX_GATES + 1, 1'b0);
        random_phase($urandom_range(1, MAX_GATES), 100, $urandom_range(0, (1 << CNT_W) - 1),
                     1'b0);
        random_phase($urandom_range(1, MAX_GATES), 100, 0, 1'b0);

        $display("Summary: %0d transactions in (%0d gate loads, %0d evaluations), %0d results",
                 items_accepted, loads_seen, evals_seen, results_seen);
        $display("Summary: %0d gate-count writes spanning 0 to %0d, %0d mismatches",
                 count_writes, (1 << CNT_W) - 1, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // driver: hold a stalled transaction, otherwise offer the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_request(offered);
                items_accepted++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                    offered = pending_items.pop_front();
                    i_valid        <= 1'b1;
                    i_func         <= offered.func;
                    i_gate_index   <= offered.index;
                    i_gate_control <= offered.control;
                    i_gate_target  <= offered.target;
                    i_gate_op      <= offered.op;
                    i_term         <= offered.term;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transaction against the oldest expected term
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_terms.size() == 0) begin
                    $display("%0t: unexpected result_term: expected none, actual %h",
                             $time, o_result_term);
                    mismatches++;
                end else begin
                    want_term = expected_terms.pop_front();
                    results_seen++;
                    if (o_result_term !== want_term) begin
                        $display("%0t: result_term mismatch: expected %h, actual %h",
                                 $time, want_term, o_result_term);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_ask && !hold_done) begin
                hold_left = HOLD_CYCLES - 1;
                hold_done = 1'b1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 10);
            end
        end
    end

    // watchdog: count cycles with work outstanding and no transaction moving
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (items_accepted == items_pushed && expected_terms.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

endmodule
